// ===== rtl/rse_pkg.sv =====
// Shared types, opcodes and reset values for the instruction execute block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

	localparam int unsigned DATA_WORDS_DEF = 16384;

	localparam logic [31:0] PC_RESET = 32'd256;
	localparam logic [31:0] SP_RESET = 32'h0000_FFFC;
	localparam logic [4:0]  ZERO_REG = 5'd0;
	localparam logic [4:0]  SP_REG   = 5'd29;
	localparam logic [4:0]  LINK_REG = 5'd31;

	localparam logic [5:0] OP_SPECIAL = 6'b000000;
	localparam logic [5:0] OP_JAL     = 6'b000011;
	localparam logic [5:0] OP_BEQ     = 6'b000100;
	localparam logic [5:0] OP_BNE     = 6'b000101;
	localparam logic [5:0] OP_ADDI    = 6'b001000;
	localparam logic [5:0] OP_ANDI    = 6'b001100;
	localparam logic [5:0] OP_ORI     = 6'b001101;
	localparam logic [5:0] OP_LW      = 6'b100011;
	localparam logic [5:0] OP_SW      = 6'b101011;

	localparam logic [5:0] FN_SLL = 6'b000000;
	localparam logic [5:0] FN_SRL = 6'b000010;
	localparam logic [5:0] FN_JR  = 6'b001000;
	localparam logic [5:0] FN_ADD = 6'b100000;
	localparam logic [5:0] FN_SUB = 6'b100010;
	localparam logic [5:0] FN_AND = 6'b100100;
	localparam logic [5:0] FN_OR  = 6'b100101;
	localparam logic [5:0] FN_NOR = 6'b100111;

	typedef struct packed {
		logic [31:0] instruction;
	} fetch_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_write;
		logic [4:0]  write_reg;
		logic [31:0] write_value;
		logic        mem_write;
		logic [31:0] mem_address;
		logic [31:0] mem_data;
		logic        branch_taken;
		logic        illegal;
	} retire_t;

	function automatic logic [31:0] rf_reset_val(input logic [4:0] idx);
		return (idx == SP_REG) ? SP_RESET : 32'd0;
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rse_stream_if.sv =====
// Valid/ready channel carrying one request payload of a given type.
// No dependencies; the payload type is supplied by the instantiating level.
`timescale 1ns / 1ps
`default_nettype none

interface rse_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/risc_subset_instruction_execute.sv =====
// Instruction execute block: register file, PC and data memory with a two-stage datapath.
// Depends on rse_pkg and rse_stream_if.
//
//   channel | modport | payload         | role
//   fetch   | sink    | rse_pkg::fetch_t  | one instruction word per request
//   retire  | source  | rse_pkg::retire_t | one result per instruction
//
// Register file read on accept, then execute and data memory access, then write-back
// into a two-entry result queue. When DATA_WORDS is not a power of two, lw and sw wait
// for the word index reduction (multiply pipeline). After reset, fetch.ready stays low
// while data memory is cleared. fetch.ready does not depend on retire.ready; intake
// stalls in the clear, on a busy execute stage, or on write-back held by a full queue.
`timescale 1ns / 1ps
`default_nettype none

module risc_subset_instruction_execute #(
	parameter int unsigned DATA_WORDS = rse_pkg::DATA_WORDS_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	rse_stream_if.sink    fetch,
	rse_stream_if.source  retire
);
	import rse_pkg::*;

	localparam int unsigned AW   = $clog2(DATA_WORDS);
	localparam bit          POW2 = ((DATA_WORDS & (DATA_WORDS - 1)) == 0);

	fetch_t      fetch_d;
	logic        fetch_acc;

	logic        clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	logic [31:0] rf_mem [32];
	logic [31:0] rf_vld_q;

	logic [31:0] dmem [DATA_WORDS];
	logic [31:0] dmem_rdata_s2;
	logic [AW-1:0] dmem_idx;
	logic        idx_ok;

	logic [31:0] pc_q;

	logic        s1_valid_q;
	logic [31:0] inst_s1;
	logic [31:0] a_s1;
	logic [31:0] b_s1;
	logic        s1_fire;

	logic [5:0]  op;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [4:0]  sh;
	logic [5:0]  fn;
	logic [31:0] imm_sx;
	logic [31:0] pc4;
	logic [31:0] eaddr;
	retire_t     dec;
	logic        dec_lw;
	logic        dec_mem;

	logic        s2_valid_q;
	retire_t     res_s2;
	logic        lw_s2;
	logic        s2_adv;
	retire_t     res_out;

	logic        wb_en;
	logic [4:0]  wb_reg;
	logic [31:0] wb_val;

	retire_t     hd_q;
	retire_t     tl_q;
	logic        hd_vld_q;
	logic        tl_vld_q;
	logic        pop;

	assign fetch_d     = fetch.data;
	assign fetch.ready = !clr_busy_q && !s1_valid_q && (!s2_valid_q || !tl_vld_q);
	assign fetch_acc   = fetch.valid && fetch.ready;

	// data memory clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == AW'(DATA_WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// register file: read on accept, write-first bypass from write-back
	always_ff @(posedge clk) begin
		if (wb_en) begin
			rf_mem[wb_reg] <= wb_val;
		end
		if (fetch_acc) begin
			inst_s1 <= fetch_d.instruction;
			if (wb_en && wb_reg == fetch_d.instruction[25:21]) begin
				a_s1 <= wb_val;
			end else if (rf_vld_q[fetch_d.instruction[25:21]]) begin
				a_s1 <= rf_mem[fetch_d.instruction[25:21]];
			end else begin
				a_s1 <= rf_reset_val(fetch_d.instruction[25:21]);
			end
			if (wb_en && wb_reg == fetch_d.instruction[20:16]) begin
				b_s1 <= wb_val;
			end else if (rf_vld_q[fetch_d.instruction[20:16]]) begin
				b_s1 <= rf_mem[fetch_d.instruction[20:16]];
			end else begin
				b_s1 <= rf_reset_val(fetch_d.instruction[20:16]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (wb_en) begin
			rf_vld_q[wb_reg] <= 1'b1;
		end
	end

	// execute stage
	assign op     = inst_s1[31:26];
	assign rt     = inst_s1[20:16];
	assign rd     = inst_s1[15:11];
	assign sh     = inst_s1[10:6];
	assign fn     = inst_s1[5:0];
	assign imm_sx = sext16(inst_s1[15:0]);
	assign pc4    = pc_q + 32'd4;
	assign eaddr  = a_s1 + imm_sx;

	always_comb begin
		dec         = '0;
		dec.next_pc = pc4;
		dec_mem     = 1'b0;
		dec_lw      = 1'b0;
		unique case (op) inside
			OP_SPECIAL: begin
				dec.reg_write = 1'b1;
				dec.write_reg = rd;
				unique case (fn)
					FN_ADD: dec.write_value = a_s1 + b_s1;
					FN_SUB: dec.write_value = a_s1 - b_s1;
					FN_AND: dec.write_value = a_s1 & b_s1;
					FN_OR:  dec.write_value = a_s1 | b_s1;
					FN_NOR: dec.write_value = ~(a_s1 | b_s1);
					FN_SLL: dec.write_value = b_s1 << sh;
					FN_SRL: dec.write_value = b_s1 >> sh;
					FN_JR: begin
						dec.reg_write    = 1'b0;
						dec.next_pc      = a_s1;
						dec.branch_taken = 1'b1;
					end
					default: begin
						dec.reg_write = 1'b0;
						dec.illegal   = 1'b1;
					end
				endcase
			end
			OP_ADDI: begin
				dec.reg_write   = 1'b1;
				dec.write_reg   = rt;
				dec.write_value = eaddr;
			end
			OP_ANDI: begin
				dec.reg_write   = 1'b1;
				dec.write_reg   = rt;
				dec.write_value = a_s1 & {16'd0, inst_s1[15:0]};
			end
			OP_ORI: begin
				dec.reg_write   = 1'b1;
				dec.write_reg   = rt;
				dec.write_value = a_s1 | {16'd0, inst_s1[15:0]};
			end
			OP_LW: begin
				dec_mem         = 1'b1;
				dec_lw          = 1'b1;
				dec.mem_address = eaddr;
				dec.reg_write   = 1'b1;
				dec.write_reg   = rt;
			end
			OP_SW: begin
				dec_mem         = 1'b1;
				dec.mem_address = eaddr;
				dec.mem_write   = 1'b1;
				dec.mem_data    = b_s1;
			end
			OP_JAL: begin
				dec.reg_write    = 1'b1;
				dec.write_reg    = LINK_REG;
				dec.write_value  = pc4;
				dec.next_pc      = {pc4[31:28], inst_s1[25:0], 2'b00};
				dec.branch_taken = 1'b1;
			end
			OP_BEQ, OP_BNE: begin
				if ((op == OP_BEQ) == (a_s1 == b_s1)) begin
					dec.next_pc      = pc4 + {imm_sx[29:0], 2'b00};
					dec.branch_taken = 1'b1;
				end
			end
			default: dec.illegal = 1'b1;
		endcase
		if (dec.reg_write && dec.write_reg == ZERO_REG) begin
			dec.reg_write = 1'b0;
		end
		if (!dec.reg_write) begin
			dec.write_reg   = '0;
			dec.write_value = '0;
			dec_lw          = 1'b0;
		end
	end

	// word index into data memory
	generate
		if (POW2) begin : g_idx_mask
			assign dmem_idx = eaddr[AW+1:2];
			assign idx_ok   = 1'b1;
		end else begin : g_idx_mod
			// (addr >> 2) mod DATA_WORDS by exact reciprocal multiply
			localparam int unsigned SH = 30 + AW;
			localparam int unsigned QW = 61 - SH;
			localparam logic [63:0] MAGIC64 =
				((64'd1 << SH) + 64'(DATA_WORDS) - 64'd1) / 64'(DATA_WORDS);
			localparam logic [30:0] MAGIC = MAGIC64[30:0];

			logic [1:0]    age_q;
			logic [29:0]   x_q;
			logic [60:0]   prod_q;
			logic [29:0]   qd_q;
			logic [QW-1:0] quo;
			logic [29:0]   rem;
			logic [29:0]   rem_fix;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					age_q <= '0;
				end else if (fetch_acc) begin
					age_q <= '0;
				end else if (age_q != 2'd3) begin
					age_q <= age_q + 2'd1;
				end
			end

			always_ff @(posedge clk) begin
				x_q    <= eaddr[31:2];
				prod_q <= 61'(x_q) * 61'(MAGIC);
				qd_q   <= 30'(quo) * 30'(DATA_WORDS);
			end

			assign quo      = prod_q[60:SH];
			assign rem      = x_q - qd_q;
			assign rem_fix  = (rem >= 30'(DATA_WORDS)) ? rem - 30'(DATA_WORDS) : rem;
			assign dmem_idx = rem_fix[AW-1:0];
			assign idx_ok   = (age_q == 2'd3);
		end
	endgenerate

	assign s1_fire = s1_valid_q && (idx_ok || !dec_mem) && (!s2_valid_q || s2_adv);

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			dmem[clr_idx_q] <= '0;
		end else if (s1_fire && dec.mem_write) begin
			dmem[dmem_idx] <= b_s1;
		end
		if (s1_fire && dec_lw) begin
			dmem_rdata_s2 <= dmem[dmem_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= PC_RESET;
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (fetch_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				pc_q       <= dec.next_pc;
				s2_valid_q <= 1'b1;
			end else if (s2_adv) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_s2 <= dec;
			lw_s2  <= dec_lw;
		end
	end

	// write-back
	assign s2_adv = s2_valid_q && !tl_vld_q;
	assign wb_en  = s2_adv && res_s2.reg_write;
	assign wb_reg = res_s2.write_reg;
	assign wb_val = lw_s2 ? dmem_rdata_s2 : res_s2.write_value;

	always_comb begin
		res_out             = res_s2;
		res_out.write_value = wb_val;
	end

	// two-entry result queue
	assign pop = hd_vld_q && retire.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_vld_q <= 1'b0;
			tl_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				hd_vld_q <= tl_vld_q || s2_adv;
				tl_vld_q <= tl_vld_q && s2_adv;
			end else if (s2_adv) begin
				hd_vld_q <= 1'b1;
				tl_vld_q <= hd_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hd_q <= tl_vld_q ? tl_q : res_out;
			if (tl_vld_q && s2_adv) begin
				tl_q <= res_out;
			end
		end else if (s2_adv) begin
			if (hd_vld_q) begin
				tl_q <= res_out;
			end else begin
				hd_q <= res_out;
			end
		end
	end

	assign retire.valid = hd_vld_q;
	assign retire.data  = hd_q;

	// checks
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_valid_q && s2_valid_q))
		else $error("execute and write-back stages both occupied");

	a_no_intake_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !fetch_acc)
		else $error("request accepted during data memory clear");

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		wb_en |-> (wb_reg != ZERO_REG))
		else $error("write-back to register zero");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		tl_vld_q |-> hd_vld_q)
		else $error("result queue tail valid without head");

	a_illegal_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && dec.illegal |-> !dec.reg_write && !dec.mem_write && !dec.branch_taken)
		else $error("unsupported instruction has side effects");

endmodule

`default_nettype wire
